>>> hw/rtl/dpb_pkg.sv
// shared constants, types and helpers for the depth pixel back-projection block
`default_nettype none

package dpb_pkg;

   // field widths
   localparam int COORD_BITS = 12;
   localparam int COL_W      = 12;
   localparam int DEPTH_W    = 16;
   localparam int BYTE_W     = 8;
   localparam int CENTRE_W   = 16;
   localparam int FACTOR_W   = 32;
   localparam int POS_W      = 32;
   localparam int Z_W        = 31;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 32;
   localparam int ORDER_W    = 2;

   // datapath widths derived from the field widths
   localparam int USE_W  = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
   localparam int FRAC_W = 4;
   localparam int PIX_W  = USE_W + FRAC_W;
   localparam int OFS_W  = ((PIX_W > CENTRE_W) ? PIX_W : CENTRE_W) + 1;
   localparam int MAG_W  = OFS_W - 1;
   localparam int PRD_W  = MAG_W + DEPTH_W;
   localparam int HALF_W = FACTOR_W / 2;
   localparam int PART_W = PRD_W + HALF_W;
   localparam int Q_W    = PART_W + 1 - FRAC_W;
   localparam int ZP_W   = DEPTH_W + FACTOR_W;
   localparam int ZSH_W  = 16;
   localparam int ZR_W   = ZP_W + 1 - ZSH_W;

   // pipeline depth
   localparam int NUM_STAGES = 6;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_COLOR_ORDER = 3'd5;

   // register reset values
   localparam logic [CENTRE_W-1:0] RST_PRINCIPAL_X = 16'd10149;
   localparam logic [CENTRE_W-1:0] RST_PRINCIPAL_Y = 16'd5862;
   localparam logic [FACTOR_W-1:0] RST_INV_FOCAL_X = 32'd4643;
   localparam logic [FACTOR_W-1:0] RST_INV_FOCAL_Y = 32'd4642;
   localparam logic [FACTOR_W-1:0] RST_DEPTH_SCALE = 32'd4294967;

   // colour order codes
   localparam logic [ORDER_W-1:0] ORDER_RGB  = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_BGR  = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_MONO = 2'd2;

   // saturation limits
   localparam logic [POS_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] SAT_NEG = 32'h8000_0000;
   localparam logic [Z_W-1:0]   SAT_Z   = 31'h7FFF_FFFF;

   // per-stage load strobes from the flow control
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } dpb_flow_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } dpb_colour_type;

   // route the colour bytes by the order register, unused code as rgb
   function automatic dpb_colour_type pick_colour(
      input logic [ORDER_W-1:0] order,
      input logic [BYTE_W-1:0]  b0,
      input logic [BYTE_W-1:0]  b1,
      input logic [BYTE_W-1:0]  b2
   );
      dpb_colour_type c;
      unique case (order)
         ORDER_BGR: begin
            c.red = b2; c.green = b1; c.blue = b0;
         end
         ORDER_MONO: begin
            c.red = b0; c.green = b0; c.blue = b0;
         end
         default: begin
            c.red = b0; c.green = b1; c.blue = b2;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dpb_req_if.sv
// request channel interface: pixel position, raw depth and colour bytes
`default_nettype none

interface dpb_req_if
   import dpb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COL_W-1:0]   column;
   logic [COL_W-1:0]   row;
   logic [DEPTH_W-1:0] raw_depth;
   logic [BYTE_W-1:0]  byte0;
   logic [BYTE_W-1:0]  byte1;
   logic [BYTE_W-1:0]  byte2;

   modport source (
      output valid, column, row, raw_depth, byte0, byte1, byte2,
      input  ready
   );
   modport sink (
      input  valid, column, row, raw_depth, byte0, byte1, byte2,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/dpb_rsp_if.sv
// result channel interface: coloured 3-d point
`default_nettype none

interface dpb_rsp_if
   import dpb_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    point_valid;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic [Z_W-1:0]          pos_z;
   logic [BYTE_W-1:0]       red;
   logic [BYTE_W-1:0]       green;
   logic [BYTE_W-1:0]       blue;

   modport source (
      output valid, point_valid, pos_x, pos_y, pos_z, red, green, blue,
      input  ready
   );
   modport sink (
      input  valid, point_valid, pos_x, pos_y, pos_z, red, green, blue,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/dpb_flow.sv
// valid/ready flow control for the six-stage back-projection pipeline
`default_nettype none

module dpb_flow
   import dpb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_ready,
   output logic        out_valid,
   input  wire logic   out_ready,
   output dpb_flow_type flow
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;
   logic                  in_acc;
   logic                  out_acc;

   // a stage can take new data when empty or when its content moves on
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   // load strobes and next valid bits
   always_comb begin
      flow.load[0] = in_valid && ready[0];
      valid_in[0]  = ready[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         flow.load[k] = valid_ff[k-1] && ready[k];
         valid_in[k]  = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NUM_STAGES-1];
   assign in_acc    = in_valid && ready[0];
   assign out_acc   = valid_ff[NUM_STAGES-1] && out_ready;

   // occupancy changes only by requests taken in and results handed out
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         $countones(valid_ff) ==
         $past($countones(valid_ff)) + int'($past(in_acc)) - int'($past(out_acc)))
      else $error("pipeline occupancy mismatch");

   // a held first stage keeps its item
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !ready[0] |=> valid_ff[0])
      else $error("stalled item lost in first stage");

   // any bubble in the pipeline lets a request in
   a_bubble: assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff) |-> in_ready)
      else $error("request refused with a free stage");

endmodule

`default_nettype wire

>>> hw/rtl/dpb_axis.sv
// one lateral axis: offset, depth product, factor product, rounding and saturation
`default_nettype none

module dpb_axis
   import dpb_pkg::*;
(
   input  wire logic                clock,
   input  wire dpb_flow_type        flow,
   input  wire logic [USE_W-1:0]    coord,
   input  wire logic [DEPTH_W-1:0]  depth,
   input  wire logic [CENTRE_W-1:0] centre,
   input  wire logic [FACTOR_W-1:0] factor,
   output logic [POS_W-1:0]         pos
);

   localparam logic [PART_W:0] RND_Q = (PART_W+1)'(1) << (HALF_W + FRAC_W - 1);

   logic [OFS_W-1:0]   pix_ext;
   logic [OFS_W-1:0]   cen_ext;
   logic               neg_in;
   logic [OFS_W-1:0]   diff_in;

   logic [MAG_W-1:0]   mag1_ff;
   logic               neg1_ff;
   logic [DEPTH_W-1:0] depth1_ff;

   logic [PRD_W-1:0]   prd2_ff;
   logic               neg2_ff;

   logic [PART_W-1:0]  hi3_ff;
   logic [PART_W-1:0]  lo3_ff;
   logic               neg3_ff;

   logic [PART_W:0]            lo_rnd;
   logic [PART_W:0]            sum_in;
   logic [Q_W-1:0]             q4_ff;
   logic                       neg4_ff;

   logic [POS_W-1:0]   pos_in;
   logic [POS_W-1:0]   pos5_ff;

   // stage 1: signed q.4 offset as sign and magnitude
   always_comb begin
      pix_ext = OFS_W'({coord, {FRAC_W{1'b0}}});
      cen_ext = OFS_W'(centre);
      neg_in  = cen_ext > pix_ext;
      diff_in = neg_in ? (cen_ext - pix_ext) : (pix_ext - cen_ext);
   end

   always_ff @(posedge clock) begin
      if (flow.load[1]) begin
         mag1_ff   <= diff_in[MAG_W-1:0];
         neg1_ff   <= neg_in;
         depth1_ff <= depth;
      end
   end

   // stage 2: magnitude times depth
   always_ff @(posedge clock) begin
      if (flow.load[2]) begin
         prd2_ff <= PRD_W'(mag1_ff) * PRD_W'(depth1_ff);
         neg2_ff <= neg1_ff;
      end
   end

   // stage 3: product times the two halves of the factor
   always_ff @(posedge clock) begin
      if (flow.load[3]) begin
         hi3_ff  <= PART_W'(prd2_ff) * PART_W'(factor[FACTOR_W-1:HALF_W]);
         lo3_ff  <= PART_W'(prd2_ff) * PART_W'(factor[HALF_W-1:0]);
         neg3_ff <= neg2_ff;
      end
   end

   // stage 4: recombine and round half away from zero to q16.16
   always_comb begin
      lo_rnd = {1'b0, lo3_ff} + RND_Q;
      sum_in = {1'b0, hi3_ff} + {{HALF_W{1'b0}}, lo_rnd[PART_W:HALF_W]};
   end

   always_ff @(posedge clock) begin
      if (flow.load[4]) begin
         q4_ff   <= sum_in[PART_W:FRAC_W];
         neg4_ff <= neg3_ff;
      end
   end

   // stage 5: apply sign and saturate
   always_comb begin
      if (neg4_ff) begin
         if (q4_ff >= {{(Q_W-POS_W){1'b0}}, SAT_NEG}) begin
            pos_in = SAT_NEG;
         end else begin
            pos_in = POS_W'(0) - q4_ff[POS_W-1:0];
         end
      end else begin
         if (q4_ff > {{(Q_W-POS_W){1'b0}}, SAT_POS}) begin
            pos_in = SAT_POS;
         end else begin
            pos_in = q4_ff[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (flow.load[5]) begin
         pos5_ff <= pos_in;
      end
   end

   assign pos = pos5_ff;

endmodule

`default_nettype wire

>>> hw/rtl/depth_pixel_backprojection.sv
// depth pixel back-projection: a request accepted is carried through stages 0 to 5 to the result
// throughput one request per cycle while no result stalls, through a six-stage valid/ready pipeline
// deepest stage is the product times one 16-bit half of the inverse focal length
// a stalled result holds in the output stage while earlier stages keep filling
// synchronous reset empties the pipeline and loads the register defaults
`default_nettype none

module depth_pixel_backprojection
   import dpb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   dpb_req_if.sink                    req_if,
   dpb_rsp_if.source                  rsp_if,
   input  wire logic                  csr_write_en,
   input  wire logic [CFG_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_DATA_W-1:0] csr_wdata
);

   typedef struct packed {
      logic           pv;
      logic [Z_W-1:0] z;
      dpb_colour_type colour;
   } side_type;

   dpb_flow_type flow;

   logic [CENTRE_W-1:0] principal_x_ff;
   logic [CENTRE_W-1:0] principal_y_ff;
   logic [FACTOR_W-1:0] inv_focal_x_ff;
   logic [FACTOR_W-1:0] inv_focal_y_ff;
   logic [FACTOR_W-1:0] depth_scale_ff;
   logic [ORDER_W-1:0]  color_order_ff;

   logic [USE_W-1:0]    col0_ff;
   logic [USE_W-1:0]    row0_ff;
   logic [DEPTH_W-1:0]  depth0_ff;
   logic                pv0_ff;
   dpb_colour_type      colour0_ff;

   logic [ZP_W-1:0]     zp1_ff;
   logic                pv1_ff;
   dpb_colour_type      colour1_ff;

   logic [ZP_W:0]       zr_sum;
   logic [Z_W-1:0]      z_in;
   side_type            side_ff [2:NUM_STAGES-1];

   logic [POS_W-1:0]    pos_x;
   logic [POS_W-1:0]    pos_y;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         principal_x_ff <= RST_PRINCIPAL_X;
         principal_y_ff <= RST_PRINCIPAL_Y;
         inv_focal_x_ff <= RST_INV_FOCAL_X;
         inv_focal_y_ff <= RST_INV_FOCAL_Y;
         depth_scale_ff <= RST_DEPTH_SCALE;
         color_order_ff <= ORDER_RGB;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_PRINCIPAL_X: principal_x_ff <= csr_wdata[CENTRE_W-1:0];
            REG_PRINCIPAL_Y: principal_y_ff <= csr_wdata[CENTRE_W-1:0];
            REG_INV_FOCAL_X: inv_focal_x_ff <= csr_wdata[FACTOR_W-1:0];
            REG_INV_FOCAL_Y: inv_focal_y_ff <= csr_wdata[FACTOR_W-1:0];
            REG_DEPTH_SCALE: depth_scale_ff <= csr_wdata[FACTOR_W-1:0];
            REG_COLOR_ORDER: color_order_ff <= csr_wdata[ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   dpb_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .flow      (flow)
   );

   // stage 0: capture request, route colour
   always_ff @(posedge clock) begin
      if (flow.load[0]) begin
         col0_ff    <= req_if.column[USE_W-1:0];
         row0_ff    <= req_if.row[USE_W-1:0];
         depth0_ff  <= req_if.raw_depth;
         pv0_ff     <= req_if.raw_depth != '0;
         colour0_ff <= pick_colour(color_order_ff, req_if.byte0, req_if.byte1,
                                   req_if.byte2);
      end
   end

   // stage 1: depth times unit scale
   always_ff @(posedge clock) begin
      if (flow.load[1]) begin
         zp1_ff     <= ZP_W'(depth0_ff) * ZP_W'(depth_scale_ff);
         pv1_ff     <= pv0_ff;
         colour1_ff <= colour0_ff;
      end
   end

   // stage 2: round half up to unsigned q15.16 and saturate range
   always_comb begin
      zr_sum = {1'b0, zp1_ff} + (ZP_W+1)'(1 << (ZSH_W - 1));
      if (zr_sum[ZP_W:ZSH_W] > ZR_W'(SAT_Z)) begin
         z_in = SAT_Z;
      end else begin
         z_in = zr_sum[ZSH_W+Z_W-1:ZSH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (flow.load[2]) begin
         side_ff[2].pv     <= pv1_ff;
         side_ff[2].z      <= z_in;
         side_ff[2].colour <= colour1_ff;
      end
   end

   // stages 3 to 5: carry range and colour alongside the lateral axes
   always_ff @(posedge clock) begin
      for (int k = 3; k < NUM_STAGES; k++) begin
         if (flow.load[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // lateral axes
   dpb_axis u_axis_x (
      .clock  (clock),
      .flow   (flow),
      .coord  (col0_ff),
      .depth  (depth0_ff),
      .centre (principal_x_ff),
      .factor (inv_focal_x_ff),
      .pos    (pos_x)
   );

   dpb_axis u_axis_y (
      .clock  (clock),
      .flow   (flow),
      .coord  (row0_ff),
      .depth  (depth0_ff),
      .centre (principal_y_ff),
      .factor (inv_focal_y_ff),
      .pos    (pos_y)
   );

   // result
   assign rsp_if.point_valid = side_ff[NUM_STAGES-1].pv;
   assign rsp_if.pos_x       = signed'(pos_x);
   assign rsp_if.pos_y       = signed'(pos_y);
   assign rsp_if.pos_z       = side_ff[NUM_STAGES-1].z;
   assign rsp_if.red         = side_ff[NUM_STAGES-1].colour.red;
   assign rsp_if.green       = side_ff[NUM_STAGES-1].colour.green;
   assign rsp_if.blue        = side_ff[NUM_STAGES-1].colour.blue;

   // a point without depth comes out at the origin on all three axes
   a_no_depth_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.point_valid |->
         rsp_if.pos_x == '0 && rsp_if.pos_y == '0 && rsp_if.pos_z == '0)
      else $error("invalid point with nonzero position");

endmodule

`default_nettype wire
